// ===== hw/rtl/rcsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_pkg
// Shared types and constants of the chunk stream deframer.
// ----------------------------------------------------------------------------
package rcsd_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

   localparam logic [16:0] CHUNK_LIMIT_RESET = 17'd128;
   localparam logic [16:0] CHUNK_LIMIT_MAX   = 17'd65536;
   localparam logic [23:0] EXT_TS_MARK       = 24'hffffff;
   localparam logic [16:0] LONG_ID_BASE      = 17'd64;

   localparam logic [1:0] HDR_FULL  = 2'd0;
   localparam logic [1:0] HDR_DELTA = 2'd1;
   localparam logic [1:0] HDR_TIME  = 2'd2;
   localparam logic [1:0] HDR_CONT  = 2'd3;

   // per chunk stream record held in the slot memory
   typedef struct packed {
      logic [31:0] timestamp;
      logic [31:0] delta;
      logic [23:0] length;
      logic [7:0]  kind;
      logic [31:0] msg_stream;
      logic [23:0] received;
   } rec_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rcsd_slot_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_slot_table
// Slot record memory, one write and one registered read port. Entries not
// written since reset read as zero.
// ----------------------------------------------------------------------------
module rcsd_slot_table
   import rcsd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [SLOT_BITS-1:0] rd_addr,
   output rec_type                   rd_data,
   input  wire logic                 wr_en,
   input  wire logic [SLOT_BITS-1:0] wr_addr,
   input  wire rec_type              wr_data
);

   rec_type               mem [SLOT_COUNT];
   rec_type               rdata_ff;
   logic                  rvld_ff;
   logic [SLOT_COUNT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvld_ff ? rdata_ff : '0;

`ifndef SYNTH
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      !rvld_ff |-> rd_data == '0)
      else $error("unwritten slot read back non-zero");
   a_valid_follows_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(wr_addr)])
      else $error("slot valid bit not set after write");
   a_no_read_write_clash: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("read and write of same slot in one cycle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rtmp_chunk_stream_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtmp_chunk_stream_deframer_core
// Chunk stream deframer: raw bytes in, tagged message payload bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the chunk stream, one byte per request. rsp_* returns one
//   request per payload byte, tagged with the message fields; a message of
//   length zero gives a single request with payload_valid low.
//   The chunk limit is written over the csr_ port while the stream is idle.
// Throughput and order:
//   A payload byte appears on rsp_ in the cycle after it is taken. Bytes are
//   taken one per cycle while the output register is free, except for a pause
//   after each basic header while the slot record is read from the slot memory
//   (one read port, registered read). An empty message appears in the cycle
//   after its last header byte, or after that slot read for a continuation header.
// Reset:
//   Synchronous. All slot records read as zero afterwards, the chunk limit
//   is 128 and the error flag is clear. No clearing pass is needed.
// Stalls:
//   The output register holds a request until rsp_tready; req_tready drops
//   while that register is full and not being drained, and for the slot
//   read cycle after each basic header, which itself waits for a free output.
// ----------------------------------------------------------------------------
module rtmp_chunk_stream_deframer_core
   import rcsd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request: [7:0] in_byte
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,
   // response: [7:0] payload_byte, [24:8] chunk_stream, [32:25] message_kind,
   // [56:33] message_size, [88:57] message_time, [120:89] message_stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,
   // [0] payload_valid, [1] first_of_message, [2] stream_error
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [2:0] {
      PH_BH0, PH_BHX, PH_MH, PH_EXT, PH_PAY, PH_LOAD
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [3:0]      hcnt_ff, hcnt_in;
   logic [31:0]     acc_ff, acc_in;
   logic [1:0]      type_ff, type_in;
   logic [16:0]     sid_ff, sid_in;
   logic [16:0]     left_ff, left_in;
   logic            err_ff, err_in;
   logic [16:0]     csize_ff;
   rec_type         rec_ff, rec_in;

   logic            ov_ff, ov_in;
   logic [127:0]    odata_ff, odata_in;
   logic [2:0]      ouser_ff, ouser_in;
   logic            olast_ff, olast_in;

   logic            out_free;
   logic            take;
   logic            rd_en;
   logic [SLOT_BITS-1:0] rd_addr;
   logic            wr_en;
   rec_type         rd_data;

   logic [16:0]     cfg_val;

   rcsd_slot_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (sid_ff[SLOT_BITS-1:0]),
      .wr_data (rec_in)
   );

   assign out_free   = !ov_ff || rsp_tready;
   assign req_tready = (phase_ff != PH_LOAD) && out_free;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      logic [7:0]  b;
      logic [3:0]  k;
      logic [3:0]  hlen;
      logic        bh_done;
      logic        hd_done;
      logic        start;
      logic        emit;
      logic        e_valid;
      logic        e_first;
      logic        e_last;
      logic [7:0]  e_byte;
      logic [31:0] hv;
      logic [23:0] rem;
      logic [23:0] rcv;
      logic [16:0] lnew;
      b        = req_tdata;
      k        = hcnt_ff;
      hlen     = 4'd3;
      bh_done  = 1'b0;
      hd_done  = 1'b0;
      start    = 1'b0;
      emit     = 1'b0;
      e_valid  = 1'b0;
      e_first  = 1'b0;
      e_last   = 1'b0;
      e_byte   = 8'd0;
      hv       = acc_ff;
      rem      = 24'd0;
      rcv      = 24'd0;
      lnew     = 17'd0;
      phase_in = phase_ff;
      hcnt_in  = hcnt_ff;
      acc_in   = acc_ff;
      type_in  = type_ff;
      sid_in   = sid_ff;
      left_in  = left_ff;
      err_in   = err_ff;
      rec_in   = rec_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;

      case (phase_ff)
         PH_BH0: begin
            if (take) begin
               type_in = b[7:6];
               sid_in  = {11'd0, b[5:0]};
               if (b[5:1] == 5'd0) begin
                  hcnt_in  = {3'd0, b[0]} + 4'd1;
                  phase_in = PH_BHX;
               end else begin
                  bh_done = 1'b1;
               end
            end
         end
         PH_BHX: begin
            if (take) begin
               if (hcnt_ff == 4'd3) begin
                  sid_in  = sid_ff + {1'b0, b, 8'd0};
                  bh_done = 1'b1;
               end else begin
                  sid_in = LONG_ID_BASE + {9'd0, b};
                  if (hcnt_ff == 4'd2) begin
                     hcnt_in = 4'd3;
                  end else begin
                     bh_done = 1'b1;
                  end
               end
            end
         end
         PH_MH: begin
            if (take) begin
               wr_en = 1'b1;
               if (k < 4'd3) begin
                  acc_in = {8'd0, acc_ff[15:0], b};
               end else if (k < 4'd6) begin
                  rec_in.length = {rec_ff.length[15:0], b};
               end else if (k == 4'd6) begin
                  rec_in.kind = b;
               end else begin
                  rec_in.msg_stream = {b, rec_ff.msg_stream[31:8]};
               end
               hcnt_in = k + 4'd1;
               case (type_ff)
                  HDR_FULL:  hlen = 4'd11;
                  HDR_DELTA: hlen = 4'd7;
                  default:   hlen = 4'd3;
               endcase
               if (hcnt_in >= hlen) begin
                  if (acc_in[23:0] == EXT_TS_MARK) begin
                     acc_in   = 32'd0;
                     hcnt_in  = 4'd0;
                     phase_in = PH_EXT;
                  end else begin
                     hv      = acc_in;
                     hd_done = 1'b1;
                  end
               end
            end
         end
         PH_EXT: begin
            if (take) begin
               acc_in  = {acc_ff[23:0], b};
               hcnt_in = hcnt_ff + 4'd1;
               if (hcnt_in >= 4'd4) begin
                  hv      = acc_in;
                  hd_done = 1'b1;
               end
            end
         end
         PH_PAY: begin
            if (take) begin
               wr_en           = 1'b1;
               e_first         = rec_ff.received == 24'd0;
               rcv             = rec_ff.received + 24'd1;
               rec_in.received = rcv;
               e_last          = rcv >= rec_ff.length;
               lnew            = (left_ff != 17'd0) ? left_ff - 17'd1 : 17'd0;
               left_in         = lnew;
               if (lnew == 17'd0 || e_last) begin
                  phase_in = PH_BH0;
               end
               emit    = 1'b1;
               e_valid = 1'b1;
               e_byte  = b;
            end
         end
         PH_LOAD: begin
            if (out_free) begin
               wr_en  = 1'b1;
               rec_in = rd_data;
               if (type_ff == HDR_CONT) begin
                  if (rd_data.received >= rd_data.length) begin
                     rec_in.timestamp = rd_data.timestamp + rd_data.delta;
                     rec_in.received  = 24'd0;
                  end
                  start = 1'b1;
               end else begin
                  phase_in = PH_MH;
               end
            end
         end
         default: begin
            phase_in = PH_BH0;
         end
      endcase

      if (bh_done) begin
         if (sid_in >= 17'(SLOT_COUNT)) begin
            err_in = 1'b1;
         end
         hcnt_in  = 4'd0;
         acc_in   = 32'd0;
         phase_in = PH_LOAD;
         rd_en    = 1'b1;
      end

      if (hd_done) begin
         if (type_ff == HDR_FULL) begin
            rec_in.timestamp = hv;
         end else begin
            rec_in.delta     = hv;
            rec_in.timestamp = rec_ff.timestamp + hv;
         end
         rec_in.received = 24'd0;
         start           = 1'b1;
      end

      if (start) begin
         if (rec_in.length == 24'd0) begin
            phase_in = PH_BH0;
            emit     = 1'b1;
            e_first  = 1'b1;
            e_last   = 1'b1;
         end else begin
            rem      = rec_in.length - rec_in.received;
            left_in  = (rem < {7'd0, csize_ff}) ? rem[16:0] : csize_ff;
            phase_in = PH_PAY;
         end
      end

      rd_addr = sid_in[SLOT_BITS-1:0];

      ov_in    = ov_ff && !rsp_tready;
      odata_in = odata_ff;
      ouser_in = ouser_ff;
      olast_in = olast_ff;
      if (emit) begin
         ov_in    = 1'b1;
         odata_in = {7'd0, rec_in.msg_stream, rec_in.timestamp, rec_in.length,
                     rec_in.kind, sid_ff, e_byte};
         ouser_in = {err_ff, e_first, e_valid};
         olast_in = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BH0;
         hcnt_ff  <= 4'd0;
         acc_ff   <= 32'd0;
         type_ff  <= 2'd0;
         sid_ff   <= 17'd0;
         left_ff  <= 17'd0;
         err_ff   <= 1'b0;
         ov_ff    <= 1'b0;
         csize_ff <= CHUNK_LIMIT_RESET;
      end else begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         acc_ff   <= acc_in;
         type_ff  <= type_in;
         sid_ff   <= sid_in;
         left_ff  <= left_in;
         err_ff   <= err_in;
         ov_ff    <= ov_in;
         if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
            csize_ff <= cfg_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff   <= rec_in;
      odata_ff <= odata_in;
      ouser_ff <= ouser_in;
      olast_ff <= olast_in;
   end

   // zero acts as one, anything above the limit is clamped
   always_comb begin
      cfg_val = csr_pwdata[16:0];
      if (cfg_val == 17'd0) begin
         cfg_val = 17'd1;
      end else if (cfg_val > CHUNK_LIMIT_MAX) begin
         cfg_val = CHUNK_LIMIT_MAX;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {15'd0, csize_ff};

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tlast  = olast_ff;

`ifndef SYNTH
   a_empty_msg_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tuser[1])
      else $error("empty message request not marked first and last");
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("stream error flag cleared");
   a_payload_has_room: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAY |-> left_ff != 17'd0)
      else $error("payload phase with no chunk bytes left");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Chunk stream deframer bench: RTMP chunk streams with random content, mostly
// well-formed and closing with noise bytes, are fed in byte by byte, partly under
// random stalls on both sides. A local parser model predicts each tagged
// request, and every response is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb
   import rcsd_pkg::*;
();

   typedef enum logic [2:0] {
      P_BH0, P_BHX, P_MH, P_EXT, P_PAY
   } model_phase_type;

   typedef struct packed {
      logic [7:0]  pbyte;
      logic        pvalid;
      logic [16:0] cstream;
      logic [7:0]  kind;
      logic [23:0] msize;
      logic [31:0] mtime;
      logic [31:0] mstream;
      logic        first;
      logic        last;
      logic        err;
   } deframed_type;

   localparam logic [2:0] CSR_CHUNK_LIMIT = 3'd0;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [127:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   rtmp_chunk_stream_deframer_core u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parser model state
   logic [31:0]     chunk_limit;
   model_phase_type phase;
   logic [3:0]      hdr_count;
   logic [31:0]     hdr_acc;
   logic [1:0]      hdr_kind;
   logic [16:0]     cur_id;
   logic [31:0]     chunk_left;
   logic            id_error;
   logic [31:0]     tbl_time  [SLOT_COUNT];
   logic [31:0]     tbl_delta [SLOT_COUNT];
   logic [23:0]     tbl_len   [SLOT_COUNT];
   logic [7:0]      tbl_kind  [SLOT_COUNT];
   logic [31:0]     tbl_mstr  [SLOT_COUNT];
   logic [23:0]     tbl_recv  [SLOT_COUNT];

   deframed_type pending_q[$];
   int        fails = 0;
   int        bytes_sent = 0;
   bit        idle_on = 1'b0;
   bit        hold_req = 1'b0;

   function automatic int slot_of(logic [16:0] id);
      return id % SLOT_COUNT;
   endfunction

   function automatic void push_result(logic [7:0] b, logic v, logic f, logic l);
      deframed_type r;
      int s;
      s = slot_of(cur_id);
      r.pbyte = b;
      r.pvalid = v;
      r.cstream = cur_id;
      r.kind = tbl_kind[s];
      r.msize = tbl_len[s];
      r.mtime = tbl_time[s];
      r.mstream = tbl_mstr[s];
      r.first = f;
      r.last = l;
      r.err = id_error;
      pending_q.push_back(r);
   endfunction

   function automatic void open_chunk();
      int s;
      logic [31:0] rem;
      s = slot_of(cur_id);
      if (tbl_len[s] == 0) begin
         phase = P_BH0;
         push_result(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
         rem = tbl_len[s] - tbl_recv[s];
         chunk_left = rem < chunk_limit ? rem : chunk_limit;
         phase = P_PAY;
      end
   endfunction

   function automatic void basic_done();
      int s;
      if (cur_id >= SLOT_COUNT) id_error = 1'b1;
      s = slot_of(cur_id);
      hdr_count = 0;
      hdr_acc = 0;
      if (hdr_kind == HDR_CONT) begin
         // continuation of a finished message opens the next one
         if (tbl_recv[s] >= tbl_len[s]) begin
            tbl_time[s] = tbl_time[s] + tbl_delta[s];
            tbl_recv[s] = 0;
         end
         open_chunk();
      end else begin
         phase = P_MH;
      end
   endfunction

   function automatic void msg_hdr_done();
      int s;
      s = slot_of(cur_id);
      if (hdr_kind == HDR_FULL) begin
         tbl_time[s] = hdr_acc;
      end else begin
         tbl_delta[s] = hdr_acc;
         tbl_time[s] = tbl_time[s] + hdr_acc;
      end
      tbl_recv[s] = 0;
      open_chunk();
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      int s;
      int k;
      int hlen;
      logic [31:0] sum;
      logic f;
      logic l;
      s = slot_of(cur_id);
      case (phase)
         P_BH0: begin
            hdr_kind = b[7:6];
            cur_id = {11'd0, b[5:0]};
            if (cur_id < 2) begin
               hdr_count = cur_id[3:0] + 4'd1;
               phase = P_BHX;
            end else begin
               basic_done();
            end
         end
         P_BHX: begin
            if (hdr_count == 3) begin
               sum = cur_id + {b, 8'h00};
               cur_id = sum[16:0];
               basic_done();
            end else begin
               cur_id = LONG_ID_BASE + b;
               if (hdr_count == 2) hdr_count = 3;
               else basic_done();
            end
         end
         P_MH: begin
            k = hdr_count;
            if (k < 3) hdr_acc = {8'h00, hdr_acc[15:0], b};
            else if (k < 6) tbl_len[s] = {tbl_len[s][15:0], b};
            else if (k == 6) tbl_kind[s] = b;
            else tbl_mstr[s] = {b, tbl_mstr[s][31:8]};
            k++;
            hdr_count = k[3:0];
            hlen = hdr_kind == HDR_FULL ? 11 : (hdr_kind == HDR_DELTA ? 7 : 3);
            if (k >= hlen) begin
               if (hdr_acc[23:0] == EXT_TS_MARK) begin
                  hdr_acc = 0;
                  hdr_count = 0;
                  phase = P_EXT;
               end else begin
                  msg_hdr_done();
               end
            end
         end
         P_EXT: begin
            hdr_acc = {hdr_acc[23:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= 4) msg_hdr_done();
         end
         P_PAY: begin
            f = tbl_recv[s] == 0;
            tbl_recv[s] = tbl_recv[s] + 24'd1;
            l = tbl_recv[s] >= tbl_len[s];
            if (chunk_left > 0) chunk_left--;
            if (chunk_left == 0 || l) phase = P_BH0;
            push_result(b, 1'b1, f, l);
         end
         default: phase = P_BH0;
      endcase
   endfunction

   function automatic void model_reset();
      chunk_limit = CHUNK_LIMIT_RESET;
      phase = P_BH0;
      hdr_count = 0;
      hdr_acc = 0;
      hdr_kind = HDR_FULL;
      cur_id = 0;
      chunk_left = 0;
      id_error = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         tbl_time[i] = 0;
         tbl_delta[i] = 0;
         tbl_len[i] = 0;
         tbl_kind[i] = 0;
         tbl_mstr[i] = 0;
         tbl_recv[i] = 0;
      end
   endfunction

   // ---------------- response side ----------------
   int hold_left = 0;
   int gap_left = 0;
   bit hold_seen = 1'b0;

   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         gap_left <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s expected %h actual %h", $time, name, e, a);
         fails++;
      end
   endtask

   always begin : response_check
      bit           hs;
      logic [127:0] d;
      logic [2:0]   u;
      logic         tl;
      deframed_type e;
      @(negedge clock);
      hs = rsp_tvalid === 1'b1 && rsp_tready && !reset;
      d = rsp_tdata;
      u = rsp_tuser;
      tl = rsp_tlast;
      @(posedge clock);
      if (hs) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected request expected none actual %h", $time, d);
            fails++;
         end else begin
            e = pending_q.pop_front();
            check_field("payload_byte", e.pbyte, d[7:0]);
            check_field("payload_valid", e.pvalid, u[0]);
            check_field("chunk_stream", e.cstream, d[24:8]);
            check_field("message_kind", e.kind, d[32:25]);
            check_field("message_size", e.msize, d[56:33]);
            check_field("message_time", e.mtime, d[88:57]);
            check_field("message_stream", e.mstream, d[120:89]);
            check_field("first_of_message", e.first, u[1]);
            check_field("last_of_message", e.last, tl);
            check_field("stream_error", e.err, u[2]);
         end
      end
   end

   // ---------------- request side ----------------
   task automatic send_byte(logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      parse_byte(b);
      bytes_sent++;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // let all responses come out and the slot read settle
   task automatic drain();
      req_tvalid <= 1'b0;
      forever begin
         @(posedge clock);
         if (pending_q.size() == 0) break;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_chunk_limit(logic [31:0] v);
      logic [16:0] c;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_CHUNK_LIMIT;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      c = v[16:0];
      chunk_limit = c == 0 ? 1 : (c > CHUNK_LIMIT_MAX ? CHUNK_LIMIT_MAX : c);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_basic(logic [1:0] t, logic [16:0] id);
      logic [16:0] v;
      if (id >= 2 && id < 64) begin
         send_byte({t, id[5:0]});
      end else begin
         v = id - LONG_ID_BASE;
         if (v < 256 && $urandom_range(0, 1)) begin
            send_byte({t, 6'd0});
            send_byte(v[7:0]);
         end else begin
            send_byte({t, 6'd1});
            send_byte(v[7:0]);
            send_byte(v[15:8]);
         end
      end
   endtask

   // header of kind t, then payload; finish carries it on in type 3 chunks
   task automatic send_message(logic [1:0] t, logic [16:0] id, logic [31:0] ts,
                               logic [23:0] len, logic [7:0] kind,
                               logic [31:0] msid, bit finish);
      logic [23:0] f;
      int s;
      s = slot_of(id);
      send_basic(t, id);
      if (t != HDR_CONT) begin
         f = ts >= EXT_TS_MARK ? EXT_TS_MARK : ts[23:0];
         send_byte(f[23:16]);
         send_byte(f[15:8]);
         send_byte(f[7:0]);
         if (t != HDR_TIME) begin
            send_byte(len[23:16]);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
            send_byte(kind);
         end
         if (t == HDR_FULL)
            for (int i = 0; i < 4; i++) send_byte(msid[8*i +: 8]);
         if (f == EXT_TS_MARK)
            for (int i = 3; i >= 0; i--) send_byte(ts[8*i +: 8]);
      end
      forever begin
         while (phase == P_PAY) send_byte($urandom);
         if (!finish || tbl_recv[s] >= tbl_len[s]) break;
         send_basic(HDR_CONT, id);
      end
   endtask

   task automatic random_message(bit wide_ids);
      logic [16:0] id;
      logic [1:0]  t;
      int s;
      if (wide_ids && $urandom_range(0, 1))
         id = $urandom_range(0, 2) == 0 ? 17'd65599 : $urandom_range(64, 65599);
      else
         id = $urandom_range(2, 63);
      s = slot_of(id);
      t = $urandom_range(0, 3);
      // stored length must be small and complete for a header that reuses it
      if ((t == HDR_TIME || t == HDR_CONT) && (tbl_len[s] > 48 || tbl_recv[s] < tbl_len[s]))
         t = HDR_DELTA;
      send_message(t, id, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 300),
                   $urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, 40), $urandom,
                   $urandom, 1'b1);
   endtask

   // ---------------- tests ----------------
   task automatic test_basic_messages();
      send_message(HDR_FULL, 17'd3, 32'd100, 24'd3, 8'd20, 32'd1, 1'b1);
      send_message(HDR_FULL, 17'd4, 32'd5, 24'd0, 8'd9, 32'd0, 1'b1);
      send_message(HDR_FULL, 17'd63, 32'hffff_fff0, 24'd2, 8'hff, 32'hffff_ffff, 1'b1);
      send_message(HDR_DELTA, 17'd3, 32'd7, 24'd1, 8'd8, 32'd0, 1'b1);
      send_message(HDR_TIME, 17'd3, 32'd40, 24'd0, 8'd0, 32'd0, 1'b1);
      send_message(HDR_CONT, 17'd3, 32'd0, 24'd0, 8'd0, 32'd0, 1'b1);
      send_message(HDR_DELTA, 17'd2, 32'hffff_ffff, 24'd1, 8'd0, 32'd0, 1'b1);
      drain();
   endtask

   task automatic test_chunk_limits();
      logic [31:0] sizes[6];
      sizes = '{32'd0, 32'd1, 32'd65536, 32'h1ffff, 32'hfffe_0005, 32'd3};
      foreach (sizes[i]) begin
         write_chunk_limit(sizes[i]);
         send_message(HDR_FULL, 17'd5, $urandom, 24'd7, 8'd18, $urandom, 1'b1);
         drain();
      end
      // abandoned message: a long one is cut by a fresh full header
      send_message(HDR_FULL, 17'd6, 32'd1, 24'hffffff, 8'd1, 32'd2, 1'b0);
      send_message(HDR_FULL, 17'd6, 32'd2, 24'd4, 8'd1, 32'd2, 1'b1);
      drain();
   endtask

   task automatic test_backpressure();
      write_chunk_limit(32'd16);
      hold_req = ~hold_req;
      send_message(HDR_FULL, 17'd7, 32'd9, 24'd60, 8'd8, 32'd3, 1'b1);
      drain();
      send_message(HDR_DELTA, 17'd7, 32'd9, 24'd5, 8'd8, 32'd0, 1'b1);
      drain();
   endtask

   task automatic test_random_streams();
      int stop_at;
      idle_on = 1'b1;
      stop_at = bytes_sent + 200;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 15) == 0) begin
            drain();
            write_chunk_limit($urandom_range(0, 7) == 0 ? $urandom_range(17, 300)
                                                       : $urandom_range(1, 16));
         end
         random_message(1'b0);
      end
      drain();
   endtask

   task automatic test_wide_ids();
      idle_on = 1'b0;
      write_chunk_limit(32'd128);
      send_message(HDR_FULL, 17'd64, 32'd1, 24'd2, 8'd3, 32'd4, 1'b1);
      send_message(HDR_FULL, 17'd319, 32'd1, 24'd2, 8'd3, 32'd4, 1'b1);
      send_message(HDR_FULL, 17'd65599, 32'd1, 24'd2, 8'd3, 32'd4, 1'b1);
      // 66 aliases onto slot 2
      send_message(HDR_FULL, 17'd2, 32'd1, 24'd3, 8'd3, 32'd4, 1'b1);
      send_message(HDR_CONT, 17'd66, 32'd0, 24'd0, 8'd0, 32'd0, 1'b1);
      for (int i = 0; i < 8; i++) random_message(1'b1);
      drain();
   endtask

   task automatic test_noise();
      for (int i = 0; i < 60; i++) send_byte($urandom);
      drain();
   endtask

   initial begin
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_messages();
      test_chunk_limits();
      test_backpressure();
      test_random_streams();
      test_wide_ids();
      test_noise();
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb failed");
      $finish;
   end

endmodule
